// ----- rtl/lznt1_pkg.sv -----
package lznt1_pkg;

	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_DRAIN = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	localparam logic [2:0] EK_NONE     = 3'd0;
	localparam logic [2:0] EK_OFFSET   = 3'd1;
	localparam logic [2:0] EK_TRUNC    = 3'd2;
	localparam logic [2:0] EK_OVERFLOW = 3'd3;
	localparam logic [2:0] EK_MISUSE   = 3'd4;

	// tuple offsets reach 2^16 once the split shift has dropped to zero
	localparam int OFF_W = 17;

endpackage

// ----- rtl/lznt1_stream_decoder.sv -----
// LZNT1 stream decoder. Feed one item per cycle: op 0 carries a compressed
// stream byte, op 1 is a drain tick that releases one pending match byte, op 2
// marks end of input. Every accepted item yields exactly one result item that
// reports the decoded byte (byte_valid), whether match bytes are still
// pending (copy_pending, then only drain ticks are legal), and the stream
// status with a sticky error kind. One item is accepted per cycle while the
// output is not stalled. The single history RAM is read when a drain tick
// is accepted and written as the byte leaves the read stage, with a bypass
// for matches at offset one. Parse state is updated at acceptance and never
// waits on history data. The history needs no clearing pass after reset.
module lznt1_stream_decoder #(
	parameter int HISTORY_BYTES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       copy_pending,
	output logic [1:0] status,
	output logic [2:0] error_kind
);

	localparam int AW = (HISTORY_BYTES > 1) ? $clog2(HISTORY_BYTES) : 1;
	localparam int PW = $clog2(HISTORY_BYTES + 1);
	localparam int OW = lznt1_pkg::OFF_W;

	typedef enum logic [2:0] {
		PH_HDR_LO,
		PH_HDR_HI,
		PH_RAW,
		PH_TOKEN,
		PH_TUPLE_HI
	} phase_t;

	// history RAM
	logic [7:0] hist_mem [HISTORY_BYTES];
	logic [7:0] rdata_s1;

	// parse state
	phase_t      phase_q, n_phase;
	logic [7:0]  hdr_lo_q, n_hdr_lo;
	logic [12:0] cbl_q, n_cbl;
	logic [PW-1:0] pos_q, n_pos;
	logic [7:0]  tag_q, n_tag;
	logic [3:0]  tok_q, n_tok;
	logic [7:0]  tlo_q, n_tlo;
	logic [OW-1:0] off_q, n_off;
	logic [12:0] rem_q, n_rem;
	logic [1:0]  st_q, n_st;
	logic [2:0]  ek_q, n_ek;

	// read stage
	logic        valid_s1;
	logic        bv_s1, mem_s1, we_s1, cp_s1, fwd_s1;
	logic [7:0]  lit_s1, fwd_data_s1;
	logic [AW-1:0] waddr_s1;
	logic [1:0]  st_s1;
	logic [2:0]  ek_s1;
	logic [7:0]  s1_byte;

	logic accept, s1_adv;
	logic rec, rd, bv, mem_src;
	logic [AW-1:0] raddr;
	logic room;
	logic [OW-1:0] pos_ext;
	logic [15:0] tup;
	logic [3:0]  shamt, cnt;
	logic [OW-1:0] t_off;
	logic [12:0] t_len;

	assign s1_adv   = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	assign pos_ext = OW'(pos_q);
	assign room    = pos_q < PW'(HISTORY_BYTES);
	// offset never exceeds position, so the distance stays inside the store
	assign raddr   = AW'(pos_ext - off_q);
	assign tup     = {data_byte, tlo_q};

	// offset/length split narrows as the position passes 16, 32, 64 ...
	always_comb begin
		cnt = '0;
		for (int k = 0; k < 12; k++) begin
			if (32'(pos_q) > (32'd16 << k))
				cnt = cnt + 4'd1;
		end
		shamt = 4'd12 - cnt;
		t_off = OW'({1'b0, tup} >> shamt) + OW'(1);
		t_len = 13'(tup & 16'((17'd1 << shamt) - 17'd1)) + 13'd3;
	end

	always_comb begin
		n_phase  = phase_q;
		n_hdr_lo = hdr_lo_q;
		n_cbl    = cbl_q;
		n_pos    = pos_q;
		n_tag    = tag_q;
		n_tok    = tok_q;
		n_tlo    = tlo_q;
		n_off    = off_q;
		n_rem    = rem_q;
		n_st     = st_q;
		n_ek     = ek_q;
		rec      = 1'b0;
		rd       = 1'b0;
		bv       = 1'b0;
		mem_src  = 1'b0;
		if (st_q == lznt1_pkg::ST_RUN) begin
			priority if (op == lznt1_pkg::OP_DRAIN) begin
				if (rem_q != '0) begin
					if (room) begin
						rd      = 1'b1;
						rec     = 1'b1;
						bv      = 1'b1;
						mem_src = 1'b1;
						n_rem   = rem_q - 13'd1;
						n_pos   = pos_q + PW'(1);
					end else begin
						n_st = lznt1_pkg::ST_ERR;
						n_ek = lznt1_pkg::EK_OVERFLOW;
					end
				end
			end else if (op == lznt1_pkg::OP_END) begin
				if (rem_q != '0) begin
					n_st = lznt1_pkg::ST_ERR;
					n_ek = lznt1_pkg::EK_MISUSE;
				end else if (phase_q == PH_HDR_LO || phase_q == PH_HDR_HI) begin
					n_st = lznt1_pkg::ST_DONE;
				end else begin
					n_st = lznt1_pkg::ST_ERR;
					n_ek = lznt1_pkg::EK_TRUNC;
				end
			end else if (op == lznt1_pkg::OP_BYTE) begin
				if (rem_q != '0) begin
					n_st = lznt1_pkg::ST_ERR;
					n_ek = lznt1_pkg::EK_MISUSE;
				end else begin
					unique case (phase_q)
						PH_HDR_LO: begin
							n_hdr_lo = data_byte;
							n_phase  = PH_HDR_HI;
						end
						PH_HDR_HI: begin
							if (data_byte == 8'd0 && hdr_lo_q == 8'd0) begin
								n_st = lznt1_pkg::ST_DONE;
							end else begin
								n_cbl   = 13'({data_byte[3:0], hdr_lo_q}) + 13'd1;
								n_pos   = '0;
								n_tok   = '0;
								n_tag   = '0;
								n_phase = data_byte[7] ? PH_TOKEN : PH_RAW;
							end
						end
						PH_RAW: begin
							bv    = 1'b1;
							n_cbl = cbl_q - 13'd1;
							if (n_cbl == '0)
								n_phase = PH_HDR_LO;
						end
						PH_TOKEN: begin
							if (tok_q == '0) begin
								n_tag = data_byte;
								n_tok = 4'd8;
								n_cbl = cbl_q - 13'd1;
								if (n_cbl == '0)
									n_phase = PH_HDR_LO;
							end else if (!tag_q[0]) begin
								if (room) begin
									rec   = 1'b1;
									bv    = 1'b1;
									n_pos = pos_q + PW'(1);
									n_cbl = cbl_q - 13'd1;
									n_tag = tag_q >> 1;
									n_tok = tok_q - 4'd1;
									if (n_cbl == '0)
										n_phase = PH_HDR_LO;
								end else begin
									n_st = lznt1_pkg::ST_ERR;
									n_ek = lznt1_pkg::EK_OVERFLOW;
								end
							end else if (cbl_q < 13'd2) begin
								n_st = lznt1_pkg::ST_ERR;
								n_ek = lznt1_pkg::EK_TRUNC;
							end else begin
								n_tlo   = data_byte;
								n_cbl   = cbl_q - 13'd1;
								n_phase = PH_TUPLE_HI;
							end
						end
						PH_TUPLE_HI: begin
							n_cbl = cbl_q - 13'd1;
							if (t_off > pos_ext) begin
								n_st = lznt1_pkg::ST_ERR;
								n_ek = lznt1_pkg::EK_OFFSET;
							end else begin
								n_off   = t_off;
								n_rem   = t_len;
								n_tag   = tag_q >> 1;
								n_tok   = (tok_q != '0) ? tok_q - 4'd1 : tok_q;
								n_phase = (n_cbl == '0) ? PH_HDR_LO : PH_TOKEN;
							end
						end
						default: n_phase = PH_HDR_LO;
					endcase
				end
			end else begin
				n_st = st_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR_LO;
			hdr_lo_q <= '0;
			cbl_q    <= '0;
			pos_q    <= '0;
			tag_q    <= '0;
			tok_q    <= '0;
			tlo_q    <= '0;
			off_q    <= '0;
			rem_q    <= '0;
			st_q     <= lznt1_pkg::ST_RUN;
			ek_q     <= lznt1_pkg::EK_NONE;
		end else if (accept) begin
			phase_q  <= n_phase;
			hdr_lo_q <= n_hdr_lo;
			cbl_q    <= n_cbl;
			pos_q    <= n_pos;
			tag_q    <= n_tag;
			tok_q    <= n_tok;
			tlo_q    <= n_tlo;
			off_q    <= n_off;
			rem_q    <= n_rem;
			st_q     <= n_st;
			ek_q     <= n_ek;
		end
	end

	// byte leaving the read stage; bypass covers a write landing as we read
	assign s1_byte = mem_s1 ? (fwd_s1 ? fwd_data_s1 : rdata_s1) : lit_s1;

	always_ff @(posedge clk) begin
		if (accept && rd)
			rdata_s1 <= hist_mem[raddr];
		if (s1_adv && we_s1)
			hist_mem[waddr_s1] <= s1_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bv_s1       <= bv;
			mem_s1      <= mem_src;
			we_s1       <= rec;
			lit_s1      <= bv ? data_byte : 8'd0;
			waddr_s1    <= AW'(pos_q);
			cp_s1       <= (n_st == lznt1_pkg::ST_RUN) && (n_rem != '0);
			st_s1       <= n_st;
			ek_s1       <= n_ek;
			fwd_s1      <= s1_adv && we_s1 && (waddr_s1 == raddr);
			fwd_data_s1 <= s1_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_byte     <= s1_byte;
			byte_valid   <= bv_s1;
			copy_pending <= cp_s1;
			status       <= st_s1;
			error_kind   <= ek_s1;
		end
	end

endmodule

// ----- rtl/lznt1_checker.sv -----
module lznt1_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic [1:0] status,
	input logic [2:0] error_kind
);

	logic seen_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_err_q <= 1'b0;
		end else if (out_valid && out_ready && status == lznt1_pkg::ST_ERR) begin
			seen_err_q <= 1'b1;
		end
	end

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && seen_err_q) |-> status == lznt1_pkg::ST_ERR)
		else $error("error status not sticky");

	a_byte_running: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_valid) |-> status == lznt1_pkg::ST_RUN)
		else $error("byte while stream not running");

	a_kind_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == lznt1_pkg::ST_ERR) == (error_kind != lznt1_pkg::EK_NONE)))
		else $error("error kind disagrees with status");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_byte)))
		else $error("stalled output item changed");

endmodule

bind lznt1_stream_decoder lznt1_checker u_lznt1_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_byte   (out_byte),
	.byte_valid (byte_valid),
	.status     (status),
	.error_kind (error_kind)
);
